// File: rtl/lsc_pkg.sv
// Package for the line segment clipper: register indexes, reset values of the
// clip window and the bit layout of the result item. No dependencies.
`default_nettype none
package lsc_pkg;

  // Index of each window register on the configuration port.
  typedef enum logic [1:0] {
    REG_WIN_LEFT   = 2'd0,
    REG_WIN_BOTTOM = 2'd1,
    REG_WIN_RIGHT  = 2'd2,
    REG_WIN_TOP    = 2'd3
  } cfg_reg_e;

  localparam int WIN_LEFT_RST   = 0;
  localparam int WIN_BOTTOM_RST = 0;
  localparam int WIN_RIGHT_RST  = 1023;
  localparam int WIN_TOP_RST    = 1023;

  // Bit of the result tdata that carries the visible flag.
  localparam int VIS_BIT = 0;

endpackage
`default_nettype wire

// File: rtl/line_segment_clip.sv
// Liang-Barsky line segment clipper against a window held in four registers.
// Depends on lsc_pkg. An item passes 7 + COORD_WIDTH register stages, the last of
// them the output register that offers its result.
// Throughput: one item per cycle while results are taken; the ready chain closes
// up bubbles, so an item is taken while the output register holds a stalled result.
// Reset (rst_ni low, asynchronous) empties every stage and loads the window
// registers with left 0, bottom 0, right 1023 and top 1023.
`default_nettype none
module line_segment_clip #(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  // Window configuration writes.
  input  wire logic                    cfg_we_i,
  input  wire logic [1:0]              cfg_addr_i,
  input  wire logic [COORD_WIDTH-1:0]  cfg_wdata_i,
  // Segment items: start_x, start_y, end_x, end_y from bit 0 up.
  input  wire logic                    s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  wire logic [((4*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata_i,
  // Result items: visible, clip_start_x, clip_start_y, clip_end_x,
  // clip_end_y from bit 0 up, then zero fill.
  output logic                         m_axis_tvalid_o,
  input  wire logic                    m_axis_tready_i,
  output logic [((1+4*COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata_o
);

  localparam int W   = COORD_WIDTH;
  localparam int NW  = W + 2;        // fraction numerator, signed
  localparam int DW  = W;            // fraction denominator, unsigned
  localparam int PW  = NW + DW + 1;  // cross product, signed
  localparam int RW  = 2 * W + 2;    // dividend and remainder
  localparam int NS  = 7 + W;        // number of pipeline stages

  typedef struct packed {
    logic [NW-1:0] num;
    logic [DW-1:0] den;
  } frac_t;

  // Data that rides along unchanged to the final add.
  typedef struct packed {
    logic [W-1:0] sx;
    logic [W-1:0] sy;
    logic [W-1:0] adx;
    logic [W-1:0] ady;
    logic         ndx;
    logic         ndy;
  } geom_t;

  typedef struct packed {
    frac_t        u1;
    frac_t        u2;
    logic         rej;
    logic [W-1:0] mag;
    logic         neg;
  } axis_t;

  // Entry and exit candidates of one axis, the entry clamped to >= 0, the exit to <= 1.
  // lo is the distance above the lower edge, hi the distance below the upper.
  function automatic axis_t axis_cand(input logic [W:0] d, input logic [W:0] lo,
                                      input logic [W:0] hi);
    axis_t         r;
    logic [W:0]    m;
    logic [NW-1:0] c1;
    logic [NW-1:0] c2;
    logic [NW-1:0] one;
    logic [NW-1:0] zero;
    m    = d[W] ? (W + 1)'(-d) : d;
    one  = NW'(1);
    zero = '0;
    if (d[W]) begin
      c1 = NW'(-$signed({hi[W], hi}));
      c2 = {lo[W], lo};
    end else begin
      c1 = NW'(-$signed({lo[W], lo}));
      c2 = {hi[W], hi};
    end
    r.mag = m[W-1:0];
    r.neg = d[W];
    r.rej = 1'b0;
    r.u1  = '{num: zero, den: DW'(1)};
    r.u2  = '{num: one, den: DW'(1)};
    if (d == '0) begin
      // Parallel to both edges of this axis: outside means rejected.
      r.rej = lo[W] | hi[W];
    end else begin
      if ($signed(c1) > $signed(zero)) begin
        r.u1 = '{num: c1, den: m[W-1:0]};
      end
      if ($signed(c2) < $signed({2'b00, m[W-1:0]})) begin
        r.u2 = '{num: c2, den: m[W-1:0]};
      end
    end
    return r;
  endfunction

  // a.num * b.den; comparing two of these compares the fractions exactly.
  function automatic logic [PW-1:0] xmul(input frac_t a, input frac_t b);
    logic signed [PW-1:0] p;
    p = $signed(a.num) * $signed({1'b0, b.den});
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // Window registers. Write only while the pipeline is empty; the block does not enforce it.
  // ---------------------------------------------------------------------------
  logic [W-1:0] win_left_q, win_bottom_q, win_right_q, win_top_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_left_q   <= W'(lsc_pkg::WIN_LEFT_RST);
      win_bottom_q <= W'(lsc_pkg::WIN_BOTTOM_RST);
      win_right_q  <= W'(lsc_pkg::WIN_RIGHT_RST);
      win_top_q    <= W'(lsc_pkg::WIN_TOP_RST);
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        lsc_pkg::REG_WIN_LEFT:   win_left_q   <= cfg_wdata_i;
        lsc_pkg::REG_WIN_BOTTOM: win_bottom_q <= cfg_wdata_i;
        lsc_pkg::REG_WIN_RIGHT:  win_right_q  <= cfg_wdata_i;
        lsc_pkg::REG_WIN_TOP:    win_top_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control. A stage loads when it is empty or its contents move on, so
  // any bubble in the pipe lets a new item in even while the output stalls.
  // ---------------------------------------------------------------------------
  logic [NS-1:0] vld_q;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !vld_q[NS-1] || m_axis_tready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= s_axis_tvalid_i;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  assign s_axis_tready_o = en[0];

  // ---------------------------------------------------------------------------
  // Stage A: deltas and distances to the four window edges.
  // ---------------------------------------------------------------------------
  logic [W-1:0] in_sx, in_sy, in_ex, in_ey;
  logic [W-1:0] a_sx_q, a_sy_q;
  logic [W:0]   a_dx_q, a_dy_q;
  logic [W:0]   a_ql_q, a_qr_q, a_qb_q, a_qt_q;

  assign in_sx = s_axis_tdata_i[W-1:0];
  assign in_sy = s_axis_tdata_i[2*W-1:W];
  assign in_ex = s_axis_tdata_i[3*W-1:2*W];
  assign in_ey = s_axis_tdata_i[4*W-1:3*W];

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      a_sx_q <= in_sx;
      a_sy_q <= in_sy;
      a_dx_q <= {in_ex[W-1], in_ex} - {in_sx[W-1], in_sx};
      a_dy_q <= {in_ey[W-1], in_ey} - {in_sy[W-1], in_sy};
      a_ql_q <= {in_sx[W-1], in_sx} - {win_left_q[W-1], win_left_q};
      a_qr_q <= {win_right_q[W-1], win_right_q} - {in_sx[W-1], in_sx};
      a_qb_q <= {in_sy[W-1], in_sy} - {win_bottom_q[W-1], win_bottom_q};
      a_qt_q <= {win_top_q[W-1], win_top_q} - {in_sy[W-1], in_sy};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage B: per-axis entry and exit fractions, entry clamped to >= 0, exit to <= 1.
  // ---------------------------------------------------------------------------
  axis_t ax_x, ax_y;
  frac_t b_u1x_q, b_u1y_q, b_u2x_q, b_u2y_q;
  logic  b_rej_q;
  geom_t b_g_q;

  assign ax_x = axis_cand(a_dx_q, a_ql_q, a_qr_q);
  assign ax_y = axis_cand(a_dy_q, a_qb_q, a_qt_q);

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      b_u1x_q <= ax_x.u1;
      b_u2x_q <= ax_x.u2;
      b_u1y_q <= ax_y.u1;
      b_u2y_q <= ax_y.u2;
      b_rej_q <= ax_x.rej | ax_y.rej;
      b_g_q   <= '{sx: a_sx_q, sy: a_sy_q, adx: ax_x.mag, ady: ax_y.mag,
                   ndx: ax_x.neg, ndy: ax_y.neg};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage C: cross products to pick the larger entry and smaller exit.
  // ---------------------------------------------------------------------------
  frac_t         c_u1x_q, c_u1y_q, c_u2x_q, c_u2y_q;
  logic [PW-1:0] c_p1a_q, c_p1b_q, c_p2a_q, c_p2b_q;
  logic          c_rej_q;
  geom_t         c_g_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      c_u1x_q <= b_u1x_q;
      c_u1y_q <= b_u1y_q;
      c_u2x_q <= b_u2x_q;
      c_u2y_q <= b_u2y_q;
      c_p1a_q <= xmul(b_u1x_q, b_u1y_q);
      c_p1b_q <= xmul(b_u1y_q, b_u1x_q);
      c_p2a_q <= xmul(b_u2x_q, b_u2y_q);
      c_p2b_q <= xmul(b_u2y_q, b_u2x_q);
      c_rej_q <= b_rej_q;
      c_g_q   <= b_g_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage D: final entry u1 and exit u2.
  // ---------------------------------------------------------------------------
  frac_t d_u1_q, d_u2_q;
  logic  d_rej_q;
  geom_t d_g_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      d_u1_q  <= ($signed(c_p1a_q) >= $signed(c_p1b_q)) ? c_u1x_q : c_u1y_q;
      d_u2_q  <= ($signed(c_p2a_q) <= $signed(c_p2b_q)) ? c_u2x_q : c_u2y_q;
      d_rej_q <= c_rej_q;
      d_g_q   <= c_g_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage E: products for the u1 < u2 test and for the four clipped offsets.
  // On a visible segment 0 <= num <= den < 2^W, so W numerator bits suffice.
  // ---------------------------------------------------------------------------
  logic [PW-1:0]  e_cu_q, e_cv_q;
  logic [2*W-1:0] e_m_q [4];
  logic [DW-1:0]  e_den1_q, e_den2_q;
  logic           e_rej_q;
  geom_t          e_g_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      e_cu_q   <= xmul(d_u1_q, d_u2_q);
      e_cv_q   <= xmul(d_u2_q, d_u1_q);
      e_m_q[0] <= d_u1_q.num[W-1:0] * d_g_q.adx;
      e_m_q[1] <= d_u1_q.num[W-1:0] * d_g_q.ady;
      e_m_q[2] <= d_u2_q.num[W-1:0] * d_g_q.adx;
      e_m_q[3] <= d_u2_q.num[W-1:0] * d_g_q.ady;
      e_den1_q <= d_u1_q.den;
      e_den2_q <= d_u2_q.den;
      e_rej_q  <= d_rej_q;
      e_g_q    <= d_g_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage F: reject when u1 >= u2; set up round half away from zero as
  // floor((2 * num * |delta| + den) / (2 * den)).
  // Then W restoring division stages, one quotient bit per stage, MSB first.
  // ---------------------------------------------------------------------------
  logic [RW-1:0] dv_r_q   [W+1][4];
  logic [W-1:0]  dv_quo_q [W+1][4];
  logic [W:0]    dv_d_q   [W+1][2];
  geom_t         dv_g_q   [W+1];
  logic          dv_rej_q [W+1];

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      for (int j = 0; j < 4; j++) begin
        dv_r_q[0][j]   <= RW'({e_m_q[j], 1'b0}) + RW'(j < 2 ? e_den1_q : e_den2_q);
        dv_quo_q[0][j] <= '0;
      end
      dv_d_q[0][0] <= {e_den1_q, 1'b0};
      dv_d_q[0][1] <= {e_den2_q, 1'b0};
      dv_rej_q[0]  <= e_rej_q | ($signed(e_cu_q) >= $signed(e_cv_q));
      dv_g_q[0]    <= e_g_q;
    end
  end

  for (genvar k = 0; k < W; k++) begin : g_div
    localparam int BIT = W - 1 - k;
    logic [RW-1:0] trial [4];
    logic [3:0]    ge;
    logic [W-1:0]  quo [4];

    always_comb begin
      for (int j = 0; j < 4; j++) begin
        trial[j]    = RW'(dv_d_q[k][j/2]) << BIT;
        ge[j]       = dv_r_q[k][j] >= trial[j];
        quo[j]      = dv_quo_q[k][j];
        quo[j][BIT] = ge[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[6+k]) begin
        for (int j = 0; j < 4; j++) begin
          dv_r_q[k+1][j]   <= ge[j] ? dv_r_q[k][j] - trial[j] : dv_r_q[k][j];
          dv_quo_q[k+1][j] <= quo[j];
        end
        dv_d_q[k+1]   <= dv_d_q[k];
        dv_rej_q[k+1] <= dv_rej_q[k];
        dv_g_q[k+1]   <= dv_g_q[k];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: start plus or minus the rounded offset, or all ones
  // with visible low for a rejected segment.
  // ---------------------------------------------------------------------------
  geom_t        fg;
  logic [W-1:0] fc [4];
  logic         out_vis_q;
  logic [W-1:0] out_c_q [4];

  assign fg    = dv_g_q[W];
  assign fc[0] = fg.ndx ? fg.sx - dv_quo_q[W][0] : fg.sx + dv_quo_q[W][0];
  assign fc[1] = fg.ndy ? fg.sy - dv_quo_q[W][1] : fg.sy + dv_quo_q[W][1];
  assign fc[2] = fg.ndx ? fg.sx - dv_quo_q[W][2] : fg.sx + dv_quo_q[W][2];
  assign fc[3] = fg.ndy ? fg.sy - dv_quo_q[W][3] : fg.sy + dv_quo_q[W][3];

  always_ff @(posedge clk_i) begin
    if (en[NS-1]) begin
      out_vis_q <= !dv_rej_q[W];
      for (int j = 0; j < 4; j++) begin
        out_c_q[j] <= dv_rej_q[W] ? '1 : fc[j];
      end
    end
  end

  assign m_axis_tvalid_o = vld_q[NS-1];
  always_comb begin
    m_axis_tdata_o = '0;
    m_axis_tdata_o[lsc_pkg::VIS_BIT] = out_vis_q;
    m_axis_tdata_o[4*W:1] = {out_c_q[3], out_c_q[2], out_c_q[1], out_c_q[0]};
  end

endmodule
`default_nettype wire

// File: rtl/lsc_checker.sv
// Port-level checks for line_segment_clip, attached by the bind at the end.
// Depends on lsc_pkg for the result bit layout.
`default_nettype none
module lsc_checker #(
  parameter int COORD_WIDTH = 16
) (
  input wire logic                    clk_i,
  input wire logic                    rst_ni,
  input wire logic                    s_axis_tready_o,
  input wire logic                    m_axis_tvalid_o,
  input wire logic                    m_axis_tready_i,
  input wire logic [((1+4*COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata_o
);

  // A rejected segment shows all four coordinates as all ones.
  a_reject_ones: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[lsc_pkg::VIS_BIT]
      |-> &m_axis_tdata_o[4*COORD_WIDTH:1])
    else $error("rejected item has coordinates other than all ones");

  // With the output register empty nothing can block the input.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled while the output is empty");

  // A full, stalled pipe stays full; the input opens only when the output is taken.
  a_full_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o && !m_axis_tready_i |=> !s_axis_tready_o || m_axis_tready_i)
    else $error("input ready rose without any item leaving");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed or dropped");

endmodule

bind line_segment_clip lsc_checker #(.COORD_WIDTH(COORD_WIDTH)) u_lsc_checker (.*);
`default_nettype wire
